// ===== sv/lru_pkg.sv =====
// Shared types and constants for the LRU page replacement block.
// Used by lru_ctrl, lru_datapath and lru_page_replacement_top; no dependencies.
package lru_pkg;

  localparam int NUM_FRAMES_DEF = 4;
  localparam int PAGE_W         = 16;
  localparam int FRAME_IDX_W    = 4;
  localparam int COUNT_W        = 16;
  localparam int OUT_DATA_W     = 40;

  typedef struct packed {
    logic capture;
    logic exec;
  } lru_cmd_t;

endpackage

// ===== sv/lru_page_replacement_top.sv =====
// LRU page replacement block, top level.
// Instantiates lru_ctrl and lru_datapath; depends on lru_pkg.
//
// Input stream: one page reference per transaction; s_tdata carries the page
// number, s_tlast marks the last reference of a sequence. Output stream: one
// result per reference, in order; m_tlast echoes s_tlast and marks the final
// fault total. After a result with m_tlast set, all frames, ranks and the
// fault count return to empty, so the next reference starts a new sequence.
//
// Sequencing: a reference is first accepted into the input register, then
// evaluated in the execute step (parallel compare of all frames, rank
// update), which updates the frame table and loads the output register with
// its result. No new reference is accepted while one waits in the execute
// step, so references are taken into the block one at a time.
// The next reference may be accepted while a result still waits in the
// output register; if the receiver holds m_tready low, execution of that
// next reference waits until the output register is free, and s_tready
// stays low meanwhile. Reset (rst, synchronous) empties all frames, clears
// ranks and the fault count, and drops m_tvalid.
module lru_page_replacement_top
  import lru_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PAGE_W-1:0]     s_tdata,  // [15:0] page_number
  input  logic                  s_tlast,  // end_of_sequence
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] hit, [4:1] frame_index, [5] evicted_valid, [21:6] evicted_page,
  // [37:22] fault_total, [39:38] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast   // sequence_done
);

  lru_cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lru_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_page  (s_tdata),
    .in_last  (s_tlast),
    .out_data (m_tdata),
    .out_last (m_tlast)
  );

endmodule

// ===== sv/lru_ctrl.sv =====
// Controller for the LRU page replacement block: input/execute sequencing
// and output valid tracking. Depends on lru_pkg.
module lru_ctrl
  import lru_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output lru_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;

  assign s_tready    = (state == S_IDLE);
  assign cmd.capture = (state == S_IDLE) && s_tvalid;
  assign cmd.exec    = (state == S_EXEC) && (!out_valid || m_tready);
  assign m_tvalid    = out_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_EXEC))
    else $error("capture not followed by execute state");

  a_exec_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> m_tvalid)
    else $error("result not presented after execute");

  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && m_tvalid && !m_tready |=> (state == S_EXEC))
    else $error("execute left while output register occupied");

endmodule

// ===== sv/lru_datapath.sv =====
// Datapath for the LRU page replacement block: frame table, recency ranks,
// fault counter, hit/victim selection and output register. Depends on lru_pkg.
module lru_datapath
  import lru_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lru_cmd_t              cmd,
  input  logic [PAGE_W-1:0]     in_page,
  input  logic                  in_last,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last
);

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int RW = FW;
  localparam logic [RW-1:0] RANK_OLDEST = RW'(NUM_FRAMES - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [PAGE_W-1:0]  page_q;
  logic               last_q;
  logic [PAGE_W-1:0]  resident_page [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] frame_valid;
  logic [RW-1:0]      recency_rank [NUM_FRAMES];
  logic [COUNT_W-1:0] fault_counter;

  logic [NUM_FRAMES-1:0] match;
  logic                  hit_c;
  logic                  empty_c;
  logic [FW-1:0]         hit_idx;
  logic [FW-1:0]         empty_idx;
  logic [FW-1:0]         victim_idx;
  logic [FW-1:0]         sel;
  logic [RW-1:0]         sel_rank;
  logic                  evict_c;
  logic [COUNT_W-1:0]    count_next;

  always_comb begin
    hit_idx    = '0;
    empty_idx  = '0;
    victim_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      match[i] = frame_valid[i] && (resident_page[i] == page_q);
      if (match[i]) hit_idx = FW'(i);
      if (!frame_valid[i]) empty_idx = FW'(i);
      if (recency_rank[i] == RANK_OLDEST) victim_idx = FW'(i);
    end
  end

  assign hit_c   = |match;
  assign empty_c = ~&frame_valid;
  assign evict_c = !hit_c && !empty_c;
  assign sel     = hit_c ? hit_idx : (empty_c ? empty_idx : victim_idx);
  assign sel_rank = recency_rank[sel];
  assign count_next = (hit_c || fault_counter == COUNT_MAX) ? fault_counter
                                                           : fault_counter + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_q <= in_page;
      last_q <= in_last;
    end
    if (cmd.exec) begin
      out_data <= {2'b00, count_next,
                   evict_c ? resident_page[sel] : {PAGE_W{1'b0}},
                   evict_c, FRAME_IDX_W'(sel), hit_c};
      out_last <= last_q;
      if (!hit_c) resident_page[sel] <= page_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      fault_counter <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) recency_rank[i] <= '0;
    end else if (cmd.exec) begin
      if (last_q) begin
        frame_valid   <= '0;
        fault_counter <= '0;
        for (int i = 0; i < NUM_FRAMES; i++) recency_rank[i] <= '0;
      end else begin
        frame_valid[sel] <= 1'b1;
        fault_counter    <= count_next;
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (FW'(i) == sel) begin
            recency_rank[i] <= '0;
          end else if (frame_valid[i] &&
                       ((!hit_c && empty_c) || recency_rank[i] < sel_rank)) begin
            recency_rank[i] <= recency_rank[i] + 1'b1;
          end
        end
      end
    end
  end

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("page resident in more than one frame");

  a_valid_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !last_q |=>
      ($countones(frame_valid) >= $past($countones(frame_valid))))
    else $error("frame lost its valid bit mid-sequence");

  a_fault_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !last_q && !hit_c |=> (fault_counter != '0))
    else $error("fault not counted");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && last_q |=> (frame_valid == '0) && (fault_counter == '0))
    else $error("state not cleared after end of sequence");

endmodule

// ===== verif/tb_lru_page_replacement_top.sv =====
// Self-checking testbench for lru_page_replacement_top: drives page references and
// compares every result with an LRU frame-table predictor kept in the testbench.
// Depends on lru_pkg and the lru_page_replacement_top RTL.
`timescale 1ns / 100ps

import lru_pkg::*;

typedef struct packed {
  logic                   hit;
  logic [FRAME_IDX_W-1:0] frame;
  logic                   ev_valid;
  logic [PAGE_W-1:0]      ev_page;
  logic [COUNT_W-1:0]     faults;
  logic                   seq_end;
} page_outcome_t;

class page_fault_tracker;
  localparam int NF = NUM_FRAMES_DEF;

  logic [PAGE_W-1:0]  frame_page [NF];
  logic               frame_used [NF];
  logic [1:0]         frame_age  [NF];
  logic [COUNT_W-1:0] fault_count;
  page_outcome_t      expected_outcomes[$];
  int                 mismatches;

  function void clear_frames();
    for (int i = 0; i < NF; i++) begin
      frame_used[i] = 1'b0;
      frame_age[i]  = 2'd0;
    end
    fault_count = '0;
  endfunction

  // old_age of NF ages every other valid frame (fresh load)
  function void make_newest(int f, int old_age);
    for (int i = 0; i < NF; i++) begin
      if (frame_used[i] && i != f && frame_age[i] < old_age) frame_age[i] = frame_age[i] + 2'd1;
    end
    frame_age[f] = 2'd0;
  endfunction

  function page_outcome_t predict_outcome(logic [PAGE_W-1:0] page, logic seq_end);
    page_outcome_t o;
    int f;
    int oldest;
    bit found;
    bit empty;
    o = '0;
    f = 0;
    found = 0;
    empty = 0;
    for (int i = 0; i < NF; i++) begin
      if (!found && frame_used[i] && frame_page[i] == page) begin
        f = i;
        found = 1;
      end
    end
    if (found) begin
      o.hit = 1'b1;
      make_newest(f, frame_age[f]);
    end else begin
      for (int i = 0; i < NF; i++) begin
        if (!empty && !frame_used[i]) begin
          f = i;
          empty = 1;
        end
      end
      if (empty) begin
        frame_used[f] = 1'b1;
        make_newest(f, NF);
      end else begin
        oldest = 0;
        f = 0;
        for (int i = 0; i < NF; i++) begin
          if (frame_age[i] > oldest) begin
            oldest = frame_age[i];
            f = i;
          end
        end
        o.ev_valid = 1'b1;
        o.ev_page  = frame_page[f];
        make_newest(f, frame_age[f]);
      end
      frame_page[f] = page;
      if (fault_count != '1) fault_count = fault_count + 1'b1;
    end
    o.frame   = f[FRAME_IDX_W-1:0];
    o.faults  = fault_count;
    o.seq_end = seq_end;
    if (seq_end) clear_frames();
    return o;
  endfunction

  function void note_reference(logic [PAGE_W-1:0] page, logic seq_end);
    expected_outcomes.push_back(predict_outcome(page, seq_end));
  endfunction

  function void compare_field(string name, logic [31:0] e, logic [31:0] g);
    if (g !== e) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, g);
      mismatches++;
    end
  endfunction

  function void check_result(logic [OUT_DATA_W-1:0] data, logic seq_end);
    page_outcome_t e;
    if (expected_outcomes.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %0h last %0b", $time, data, seq_end);
      mismatches++;
      return;
    end
    e = expected_outcomes.pop_front();
    compare_field("hit", e.hit, data[0]);
    compare_field("frame_index", e.frame, data[4:1]);
    compare_field("evicted_valid", e.ev_valid, data[5]);
    compare_field("evicted_page", e.ev_page, data[21:6]);
    compare_field("fault_total", e.faults, data[37:22]);
    compare_field("pad", 0, data[39:38]);
    compare_field("sequence_done", e.seq_end, seq_end);
  endfunction

  function int outstanding();
    return expected_outcomes.size();
  endfunction
endclass

module tb_lru_page_replacement_top;
  localparam int RANDOM_ITEMS = 1650;
  localparam int HOLD_CYCLES  = 400;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PAGE_W-1:0]     s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  page_fault_tracker sb;
  bit                idle_enable;
  bit                hold_request;
  int                sent;

  lru_page_replacement_top #(
    .NUM_FRAMES(NUM_FRAMES_DEF)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_reference(input logic [PAGE_W-1:0] page, input logic seq_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= page;
    s_tlast  <= seq_end;
    do @(posedge clk); while (!s_tready);
    sb.note_reference(page, seq_end);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_random_sequence();
    int len;
    int pool;
    bit noise;
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] page;
    len   = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 60);
    pool  = $urandom_range(2, 8);
    noise = ($urandom_range(0, 4) == 0);
    base  = PAGE_W'($urandom);
    idle_enable = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < len; k++) begin
      if (noise || $urandom_range(0, 19) == 0) page = PAGE_W'($urandom);
      else page = base ^ PAGE_W'($urandom_range(0, pool - 1));
      send_reference(page, k == len - 1);
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  initial begin
    logic [PAGE_W-1:0] dir_page [16];
    logic              dir_end  [16];
    sb = new();
    sb.clear_frames();
    sb.mismatches = 0;
    idle_enable  = 1;
    hold_request = 0;
    sent     = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill, hit middle and oldest, LRU evictions, end of sequence, fresh start
    dir_page = '{16'h0000, 16'hFFFF, 16'h1234, 16'hABCD, 16'hFFFF, 16'h0000,
                 16'h5555, 16'h1234, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA,
                 16'h0000, 16'h0000, 16'hFFFF, 16'h0000};
    dir_end  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1};
    for (int k = 0; k < 16; k++) send_reference(dir_page[k], dir_end[k]);

    hold_request = 1;
    while (sent < RANDOM_ITEMS) send_random_sequence();
    s_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
